// File: hdl/bit_vector_insert_remove_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bit vector insert/remove block
// Clocked implication helpers, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_INSERT_REMOVE_ASSERT_SVH
`define BIT_VECTOR_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication
`define BVIR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bvir assertion failed");

// Next-cycle implication
`define BVIR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bvir assertion failed");

`endif

// File: hdl/bvir_pkg.sv
// ----------------------------------------------------------------------------
// bvir_pkg
// Types, codes and helpers shared by the bit vector insert/remove block.
// ----------------------------------------------------------------------------
package bvir_pkg;

    // Storage geometry
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    // Item field widths
    localparam int OP_W  = 4;
    localparam int POS_W = 8;
    localparam int LEN_W = 7;
    localparam int ST_W  = 2;

    // Width for signed index resolution (position plus length)
    localparam int RES_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_INSERT     = 4'd2,
        OP_REMOVE     = 4'd3,
        OP_POP_BACK   = 4'd4,
        OP_POP_FRONT  = 4'd5,
        OP_SET        = 4'd6,
        OP_GET        = 4'd7,
        OP_REVERSE    = 4'd8
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef logic [CAPACITY-1:0] store_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [IDX_W-1:0]    index_t;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [POS_W-1:0] position;
        logic                    bit_value;
    } item_t;

    typedef struct packed {
        logic             read_bit;
        logic [LEN_W-1:0] length;
        status_t          status;
    } result_t;

    typedef struct packed {
        store_t store;
        count_t count;
    } state_t;

    // Ones in the n lowest bits, all ones when n reaches the capacity
    function automatic store_t low_mask(input count_t n);
        store_t m;
        if (n >= count_t'(CAPACITY)) begin
            m = '1;
        end else begin
            m = (store_t'(1) << n) - store_t'(1);
        end
        return m;
    endfunction

endpackage

// File: hdl/bvir_in_stage.sv
// ----------------------------------------------------------------------------
// bvir_in_stage
// Input register: captures one item and holds it until the datapath takes it.
// ----------------------------------------------------------------------------
module bvir_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // position[7:0], bit_value[8], zeros
    input  logic [3:0]            s_tuser,   // opcode[3:0]
    input  logic                  take,
    output logic                  item_valid,
    output bvir_pkg::item_t       item
);

    logic            valid_reg;
    logic            valid_next;
    bvir_pkg::item_t item_reg;
    logic            accept;

    // Free slot when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.opcode    <= s_tuser;
            item_reg.position  <= s_tdata[bvir_pkg::POS_W-1:0];
            item_reg.bit_value <= s_tdata[bvir_pkg::POS_W];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hdl/bvir_datapath.sv
// ----------------------------------------------------------------------------
// bvir_datapath
// Combinational operation logic: index resolution, insert/remove shifts,
// set, get and reverse, plus status and new length.
// ----------------------------------------------------------------------------
module bvir_datapath (
    input  bvir_pkg::state_t  cur,
    input  bvir_pkg::item_t   item,
    output bvir_pkg::state_t  nxt,
    output bvir_pkg::result_t res
);

    localparam int RW = bvir_pkg::RES_W;
    localparam int CW = bvir_pkg::CNT_W;
    localparam int PW = bvir_pkg::POS_W;

    logic signed [RW-1:0] pos_ext;
    logic signed [RW-1:0] cnt_ext;
    logic signed [RW-1:0] pos_adj;
    logic                 ok_ins;
    logic                 ok_acc;
    bvir_pkg::index_t     idx;
    bvir_pkg::index_t     ins_idx;
    bvir_pkg::index_t     rem_idx;
    bvir_pkg::index_t     last_idx;
    logic                 is_full;
    logic                 is_empty;
    bvir_pkg::store_t     ins_mask;
    bvir_pkg::store_t     rem_mask;
    bvir_pkg::store_t     ins_store;
    bvir_pkg::store_t     rem_store;
    bvir_pkg::store_t     set_store;
    bvir_pkg::store_t     rev_full;
    bvir_pkg::store_t     rev_store;
    bvir_pkg::count_t     rev_shift;

    // Resolve position: negative counts back from the current length
    assign pos_ext = {{(RW-PW){item.position[PW-1]}}, item.position};
    assign cnt_ext = $signed({{(RW-CW){1'b0}}, cur.count});
    assign pos_adj = pos_ext[RW-1] ? (pos_ext + cnt_ext) : pos_ext;
    assign ok_ins  = !pos_adj[RW-1] && (pos_adj <= cnt_ext);
    assign ok_acc  = !pos_adj[RW-1] && (pos_adj < cnt_ext);
    assign idx     = pos_adj[bvir_pkg::IDX_W-1:0];

    assign is_full  = (cur.count >= bvir_pkg::count_t'(bvir_pkg::CAPACITY));
    assign is_empty = (cur.count == '0);
    assign last_idx = bvir_pkg::IDX_W'(cur.count - bvir_pkg::count_t'(1));

    // Index used by the shared insert and remove shifters
    always_comb begin
        ins_idx = idx;
        rem_idx = idx;
        case (bvir_pkg::opcode_t'(item.opcode))
            bvir_pkg::OP_PUSH_BACK:  ins_idx = cur.count[bvir_pkg::IDX_W-1:0];
            bvir_pkg::OP_PUSH_FRONT: ins_idx = '0;
            bvir_pkg::OP_POP_BACK:   rem_idx = last_idx;
            bvir_pkg::OP_POP_FRONT:  rem_idx = '0;
            default: begin
            end
        endcase
    end

    // Insert: bits from the index upward move up by one
    assign ins_mask  = bvir_pkg::low_mask(bvir_pkg::count_t'(ins_idx));
    assign ins_store = (cur.store & ins_mask)
                     | (bvir_pkg::store_t'(item.bit_value) << ins_idx)
                     | ((cur.store & ~ins_mask) << 1);

    // Remove: bits above the index move down by one
    assign rem_mask  = bvir_pkg::low_mask(bvir_pkg::count_t'(rem_idx));
    assign rem_store = (cur.store & rem_mask) | ((cur.store >> 1) & ~rem_mask);

    // Set one bit in place
    always_comb begin
        set_store      = cur.store;
        set_store[idx] = item.bit_value;
    end

    // Reverse the held bits: mirror the whole word, then align to bit 0
    always_comb begin
        for (int i = 0; i < bvir_pkg::CAPACITY; i++) begin
            rev_full[bvir_pkg::CAPACITY-1-i] = cur.store[i];
        end
    end
    assign rev_shift = bvir_pkg::count_t'(bvir_pkg::CAPACITY) - cur.count;
    assign rev_store = rev_full >> rev_shift;

    // Operation select
    always_comb begin
        nxt          = cur;
        res.read_bit = 1'b0;
        res.status   = bvir_pkg::ST_OK;
        case (bvir_pkg::opcode_t'(item.opcode))
            bvir_pkg::OP_PUSH_BACK, bvir_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    res.status = bvir_pkg::ST_FULL;
                end else begin
                    nxt.store = ins_store;
                    nxt.count = cur.count + bvir_pkg::count_t'(1);
                end
            end
            bvir_pkg::OP_INSERT: begin
                if (!ok_ins) begin
                    res.status = bvir_pkg::ST_RANGE;
                end else if (is_full) begin
                    res.status = bvir_pkg::ST_FULL;
                end else begin
                    nxt.store = ins_store;
                    nxt.count = cur.count + bvir_pkg::count_t'(1);
                end
            end
            bvir_pkg::OP_REMOVE: begin
                if (is_empty) begin
                    res.status = bvir_pkg::ST_EMPTY;
                end else if (!ok_acc) begin
                    res.status = bvir_pkg::ST_RANGE;
                end else begin
                    nxt.store = rem_store;
                    nxt.count = cur.count - bvir_pkg::count_t'(1);
                end
            end
            bvir_pkg::OP_POP_BACK, bvir_pkg::OP_POP_FRONT: begin
                if (is_empty) begin
                    res.status = bvir_pkg::ST_EMPTY;
                end else begin
                    nxt.store = rem_store;
                    nxt.count = cur.count - bvir_pkg::count_t'(1);
                end
            end
            bvir_pkg::OP_SET: begin
                if (!ok_acc) begin
                    res.status = bvir_pkg::ST_RANGE;
                end else begin
                    nxt.store = set_store;
                end
            end
            bvir_pkg::OP_GET: begin
                if (!ok_acc) begin
                    res.status = bvir_pkg::ST_RANGE;
                end else begin
                    res.read_bit = cur.store[idx];
                end
            end
            bvir_pkg::OP_REVERSE: begin
                if (cur.count >= bvir_pkg::count_t'(2)) begin
                    nxt.store = rev_store;
                end
            end
            default: begin
            end
        endcase
        res.length = bvir_pkg::LEN_W'(nxt.count);
    end

endmodule

// File: hdl/bit_vector_insert_remove.sv
// ----------------------------------------------------------------------------
// bit_vector_insert_remove
// Ordered bit sequence store with push, pop, insert, remove, set, get and
// reverse; one result item for every input item.
// ----------------------------------------------------------------------------
// Holds up to 64 bits (bit 0 is the front) and their count. Each input item
// gives an opcode on s_tuser and position/bit_value on s_tdata; each answers
// with one result item carrying the bit read, the new length and a status
// (ok, index out of range, full, empty). One item is taken every cycle when
// the result side keeps up; each item passes through the input register, then
// through the combinational shift and mask datapath into the result register,
// which also updates the stored sequence. A stalled result holds the input
// register, and s_tready drops once that register is occupied.
module bit_vector_insert_remove (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // position[7:0], bit_value[8], zeros
    input  logic [3:0]  s_tuser,   // opcode[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_bit[0], length[7:1], status[9:8], zeros
);

    logic               item_valid;
    bvir_pkg::item_t    item;
    logic               take;
    bvir_pkg::state_t   state_reg;
    bvir_pkg::state_t   state_next;
    bvir_pkg::result_t  res_next;
    bvir_pkg::result_t  res_reg;
    logic               out_valid_reg;

    // Held item moves on when the result register is free or being drained
    assign take = item_valid && (!out_valid_reg || m_tready);

    bvir_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    bvir_datapath u_dp (
        .cur  (state_reg),
        .item (item),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Sequence state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, res_reg.status, res_reg.length, res_reg.read_bit};

endmodule

// File: hdl/bvir_checker.sv
// ----------------------------------------------------------------------------
// bvir_checker
// Port-level checks on the result channel of the bit vector block.
// ----------------------------------------------------------------------------
`include "bit_vector_insert_remove_assert.svh"

module bvir_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    localparam logic [6:0] CAP_LEN = 7'(bvir_pkg::CAPACITY);

    logic [6:0] len;
    logic [1:0] st;
    logic       st_ok;
    logic       st_full;
    logic       st_empty;

    assign len      = m_tdata[7:1];
    assign st       = m_tdata[9:8];
    assign st_ok    = (st == bvir_pkg::ST_OK);
    assign st_full  = (st == bvir_pkg::ST_FULL);
    assign st_empty = (st == bvir_pkg::ST_EMPTY);

    // A stalled result keeps its payload
    `BVIR_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Full is only reported with the sequence at capacity
    `BVIR_ASSERT_SAME(a_full_len, aclk, aresetn, m_tvalid && st_full, len == CAP_LEN)

    // Empty is only reported with nothing held
    `BVIR_ASSERT_SAME(a_empty_len, aclk, aresetn, m_tvalid && st_empty, len == 7'd0)

    // A read bit of one only comes with a successful get
    `BVIR_ASSERT_SAME(a_read_ok, aclk, aresetn, m_tvalid && m_tdata[0], st_ok && len != 7'd0)

    // Length never exceeds capacity
    `BVIR_ASSERT_SAME(a_len_cap, aclk, aresetn, m_tvalid, len <= CAP_LEN)

endmodule

bind bit_vector_insert_remove bvir_checker u_bvir_checker (.*);

// File: tb/tb_bit_vector_insert_remove.sv
// ----------------------------------------------------------------------------
// tb_bit_vector_insert_remove
// Self-checking testbench for the bit vector insert/remove block.
// ----------------------------------------------------------------------------
// Operations go in on the slave stream and are mirrored in a local model of
// the bit sequence. Each accepted item queues the result that the model
// predicts, and every result item leaving the master stream is checked field
// by field against the oldest queued prediction. The run covers the edge
// cases, filling to capacity under a long result-side hold-off, and random
// traffic under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_bit_vector_insert_remove;

    localparam int CLK_HALF    = 2;
    localparam int RESET_LEN   = 9;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_GAP     = 20;

    // Opcodes with no operation behind them
    localparam logic [bvir_pkg::OP_W-1:0] OP_SPARE_LO = 4'd9;
    localparam logic [bvir_pkg::OP_W-1:0] OP_SPARE_HI = 4'd15;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // position[7:0], bit_value[8], zeros
    logic [3:0]  s_tuser;   // opcode[3:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // read_bit[0], length[7:1], status[9:8], zeros

    // Local copy of the sequence and its length
    bvir_pkg::store_t  seq_bits;
    int                seq_len;

    bvir_pkg::result_t expected_results[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_left;
    int errors;
    int items_sent;
    int results_seen;
    int cycle_count;
    int longest_seen;
    int status_hits[4];

    bit_vector_insert_remove u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Applies one operation to the local sequence and returns its answer
    function automatic bvir_pkg::result_t apply_bit_op(
        input logic [bvir_pkg::OP_W-1:0]         op,
        input logic signed [bvir_pkg::POS_W-1:0] pos,
        input logic                              bv
    );
        bvir_pkg::result_t ans;
        bvir_pkg::status_t st;
        bvir_pkg::store_t  flipped;
        logic    rd;
        int      idx;
        int      add_at;
        int      drop_at;
        st      = bvir_pkg::ST_OK;
        rd      = 1'b0;
        add_at  = -1;
        drop_at = -1;
        idx     = pos;
        if (idx < 0) begin
            idx = idx + seq_len;
        end
        case (op)
            bvir_pkg::OP_PUSH_BACK, bvir_pkg::OP_PUSH_FRONT: begin
                if (seq_len >= bvir_pkg::CAPACITY) st = bvir_pkg::ST_FULL;
                else add_at = (op == bvir_pkg::OP_PUSH_BACK) ? seq_len : 0;
            end
            bvir_pkg::OP_INSERT: begin
                // index is checked before fullness
                if (idx < 0 || idx > seq_len) st = bvir_pkg::ST_RANGE;
                else if (seq_len >= bvir_pkg::CAPACITY) st = bvir_pkg::ST_FULL;
                else add_at = idx;
            end
            bvir_pkg::OP_REMOVE: begin
                if (seq_len == 0) st = bvir_pkg::ST_EMPTY;
                else if (idx < 0 || idx > seq_len - 1) st = bvir_pkg::ST_RANGE;
                else drop_at = idx;
            end
            bvir_pkg::OP_POP_BACK, bvir_pkg::OP_POP_FRONT: begin
                if (seq_len == 0) st = bvir_pkg::ST_EMPTY;
                else drop_at = (op == bvir_pkg::OP_POP_BACK) ? seq_len - 1 : 0;
            end
            bvir_pkg::OP_SET, bvir_pkg::OP_GET: begin
                if (seq_len == 0 || idx < 0 || idx > seq_len - 1) st = bvir_pkg::ST_RANGE;
                else if (op == bvir_pkg::OP_SET) seq_bits[idx] = bv;
                else rd = seq_bits[idx];
            end
            bvir_pkg::OP_REVERSE: begin
                flipped = '0;
                for (int i = 0; i < seq_len; i++) begin
                    flipped[seq_len - 1 - i] = seq_bits[i];
                end
                seq_bits = flipped;
            end
            default: ;
        endcase
        // bits above the insertion point move up one place
        if (add_at >= 0) begin
            for (int i = bvir_pkg::CAPACITY - 1; i > add_at; i--) begin
                seq_bits[i] = seq_bits[i - 1];
            end
            seq_bits[add_at] = bv;
            seq_len++;
        end
        // bits above the removed one move down one place
        if (drop_at >= 0) begin
            for (int i = drop_at; i < bvir_pkg::CAPACITY - 1; i++) begin
                seq_bits[i] = seq_bits[i + 1];
            end
            seq_bits[bvir_pkg::CAPACITY - 1] = 1'b0;
            seq_len--;
        end
        ans.read_bit = rd;
        ans.length   = bvir_pkg::LEN_W'(seq_len);
        ans.status   = st;
        return ans;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // Offers one item, with a random gap ahead of it, and waits for acceptance
    task automatic send_op(input logic [bvir_pkg::OP_W-1:0] op, input int pos,
                           input logic bv);
        int gap;
        logic signed [bvir_pkg::POS_W-1:0] pos8;
        gap  = 0;
        pos8 = pos[bvir_pkg::POS_W-1:0];
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {7'b0, bv, pos8};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(apply_bit_op(op, pos8, bv));
        items_sent++;
    endtask

    // Result side: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Result checking
    always @(posedge aclk) begin
        bvir_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            status_hits[m_tdata[9:8]]++;
            if (m_tdata[7:1] > longest_seen) longest_seen = m_tdata[7:1];
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("read_bit", want.read_bit, m_tdata[0]);
                check_field("length", want.length, m_tdata[7:1]);
                check_field("status", want.status, m_tdata[9:8]);
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run timed out with %0d results outstanding", $time,
                 expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Empty-sequence cases, index resolution and odd opcodes
    task automatic test_directed_edges();
        send_op(bvir_pkg::OP_POP_BACK, 0, 1'b0);
        send_op(bvir_pkg::OP_POP_FRONT, 0, 1'b0);
        send_op(bvir_pkg::OP_REMOVE, 0, 1'b0);
        send_op(bvir_pkg::OP_GET, 0, 1'b0);
        send_op(bvir_pkg::OP_SET, -1, 1'b1);
        send_op(bvir_pkg::OP_REVERSE, 0, 1'b0);
        send_op(bvir_pkg::OP_PUSH_BACK, 0, 1'b1);
        send_op(bvir_pkg::OP_REVERSE, 0, 1'b0);      // single bit, no change
        send_op(bvir_pkg::OP_PUSH_FRONT, 0, 1'b0);
        send_op(bvir_pkg::OP_INSERT, 1, 1'b1);
        send_op(bvir_pkg::OP_INSERT, 3, 1'b0);       // at the length: appends
        send_op(bvir_pkg::OP_INSERT, 5, 1'b1);       // beyond the length
        send_op(bvir_pkg::OP_INSERT, -4, 1'b1);      // negative, resolves to front
        send_op(bvir_pkg::OP_GET, 5, 1'b0);          // at the length: out of range
        send_op(bvir_pkg::OP_GET, -1, 1'b0);
        send_op(bvir_pkg::OP_GET, -5, 1'b0);
        send_op(bvir_pkg::OP_GET, -6, 1'b0);         // still negative after resolving
        send_op(bvir_pkg::OP_SET, -1, 1'b1);
        send_op(bvir_pkg::OP_REMOVE, -2, 1'b0);
        send_op(bvir_pkg::OP_REVERSE, 0, 1'b0);
        send_op(bvir_pkg::OP_GET, 127, 1'b1);
        send_op(bvir_pkg::OP_SET, -128, 1'b1);
        send_op(OP_SPARE_LO, -1, 1'b1);
        send_op(OP_SPARE_HI, 127, 1'b1);
        send_op(bvir_pkg::OP_POP_FRONT, 0, 1'b0);
    endtask

    // Fill to capacity while results are held back, then probe the full state
    task automatic test_full_under_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = 150;
        while (seq_len < bvir_pkg::CAPACITY) begin
            send_op(bvir_pkg::OP_PUSH_BACK, 0, 1'($urandom));
        end
        send_op(bvir_pkg::OP_PUSH_BACK, 0, 1'b1);
        send_op(bvir_pkg::OP_PUSH_FRONT, 0, 1'b1);
        send_op(bvir_pkg::OP_INSERT, 0, 1'b1);
        send_op(bvir_pkg::OP_INSERT, 64, 1'b1);
        send_op(bvir_pkg::OP_INSERT, 65, 1'b1);      // bad index wins over full
        send_op(bvir_pkg::OP_INSERT, -65, 1'b1);
        send_op(bvir_pkg::OP_GET, 63, 1'b0);
        send_op(bvir_pkg::OP_GET, -64, 1'b0);
        send_op(bvir_pkg::OP_REVERSE, 0, 1'b0);
        send_op(bvir_pkg::OP_GET, 0, 1'b0);
        send_op(bvir_pkg::OP_SET, 63, 1'b0);
        send_op(bvir_pkg::OP_REMOVE, -1, 1'b0);
        send_op(bvir_pkg::OP_PUSH_FRONT, 0, 1'b1);
        repeat (10) send_op(bvir_pkg::OP_POP_FRONT, 0, 1'b0);
    endtask

    // Random traffic drifting between empty and full
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        logic [bvir_pkg::OP_W-1:0] op;
        int  pick;
        int  pos;
        bit  growing;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        growing            = 1'b1;
        repeat (count) begin
            if (seq_len >= bvir_pkg::CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
            if (seq_len == 0 && $urandom_range(3) == 0) growing = 1'b1;
            pick = $urandom_range(99);
            if (pick < 3) begin
                op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            end else if (pick < 8) begin
                op = bvir_pkg::OP_REVERSE;
            end else if (pick < 18) begin
                op = bvir_pkg::OP_GET;
            end else if (pick < 28) begin
                op = bvir_pkg::OP_SET;
            end else if ((pick - 28) < (growing ? 50 : 22)) begin
                case ($urandom_range(3))
                    0:       op = bvir_pkg::OP_PUSH_BACK;
                    1:       op = bvir_pkg::OP_PUSH_FRONT;
                    default: op = bvir_pkg::OP_INSERT;
                endcase
            end else begin
                case ($urandom_range(3))
                    0:       op = bvir_pkg::OP_POP_BACK;
                    1:       op = bvir_pkg::OP_POP_FRONT;
                    default: op = bvir_pkg::OP_REMOVE;
                endcase
            end
            // mostly near the valid range, sometimes anything the field holds
            if ($urandom_range(9) == 0) begin
                pos = $signed(8'($urandom));
            end else begin
                pos = int'($urandom_range(2 * seq_len + 2)) - (seq_len + 1);
            end
            send_op(op, pos, 1'($urandom));
        end
    endtask

    initial begin
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = '0;
        m_tready           = 1'b0;
        seq_bits           = '0;
        seq_len            = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = 0;
        errors             = 0;
        items_sent         = 0;
        results_seen       = 0;
        longest_seen       = 0;
        status_hits        = '{default: 0};
        repeat (RESET_LEN) @(negedge aclk);
        aresetn = 1'b1;

        test_directed_edges();
        test_full_under_backpressure();
        test_random_traffic(440, 0, 0);
        test_random_traffic(440, 68, 0);
        test_random_traffic(440, 0, 68);
        test_random_traffic(440, 10, 10);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d operations, checked %0d results; longest sequence %0d bits",
                 items_sent, results_seen, longest_seen);
        $display("Status seen: ok %0d, bad index %0d, full %0d, empty %0d",
                 status_hits[bvir_pkg::ST_OK], status_hits[bvir_pkg::ST_RANGE],
                 status_hits[bvir_pkg::ST_FULL], status_hits[bvir_pkg::ST_EMPTY]);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
